### design/assert_macros.svh
// assertion macros shared by the line follower rtl
// no dependencies; ASSERT_OFF compiles the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/lfps_pkg.sv
// types, widths and constants of the line follower steering block
// no dependencies; used by every module of the block
package lfps_pkg;

   localparam int DUTY_W    = 11;
   localparam int SPEED_W   = 10;
   localparam int CNT_W     = 8;
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 13;
   localparam int ERR_W     = 13;
   localparam int SUM_W     = 14;
   localparam int MAG_W     = 13;
   localparam int TOTAL_W   = 4;
   localparam int SIDE_W    = 3;
   localparam int PROD_W    = 31;
   localparam int ACC_W     = 32;
   localparam int WHEEL_W   = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int DIV_STEPS = 7;
   localparam int DIV_CNT_W = 3;

   localparam logic [SPEED_W-1:0] BASE_SPEED_RST   = 10'd700;
   localparam logic [SPEED_W-1:0] TURN_SPEED_RST   = 10'd900;
   localparam logic [SPEED_W-1:0] SEARCH_SPEED_RST = 10'd450;
   localparam logic [CNT_W-1:0]   PRE_TURN_RST     = 8'd30;
   localparam logic [CNT_W-1:0]   TURN_HOLD_RST    = 8'd15;
   localparam logic [GAIN_W-1:0]  KP_RST           = 16'd7864;
   localparam logic [GAIN_W-1:0]  KD_RST           = 16'd52429;
   localparam logic [LIMIT_W-1:0] STEER_LIMIT_RST  = 13'd500;

   localparam logic [TOTAL_W-1:0] JUNCTION_MIN = 4'd4;

   // bit 0 is the far right sensor
   localparam logic signed [ERR_W-1:0] SENSOR_WEIGHT [8] = '{
      13'sd3500, 13'sd2500, 13'sd1500, 13'sd500,
      -13'sd500, -13'sd1500, -13'sd2500, -13'sd3500
   };

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_STOP  = 2'd2,
      REQ_TURN  = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_SPEED   = 3'd0,
      CSR_TURN_SPEED   = 3'd1,
      CSR_SEARCH_SPEED = 3'd2,
      CSR_PRE_TURN_LEN = 3'd3,
      CSR_TURN_HOLD    = 3'd4,
      CSR_KP           = 3'd5,
      CSR_KD           = 3'd6,
      CSR_STEER_LIMIT  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_NONE   = 2'd0,
      OUT_DIRECT = 2'd1,
      OUT_PD     = 2'd2
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'd0,
      ST_EVAL  = 4'd1,
      ST_DIV   = 4'd2,
      ST_MUL_P = 4'd3,
      ST_MUL_D = 4'd4,
      ST_ACC   = 4'd5,
      ST_STEER = 4'd6,
      ST_WHEEL = 4'd7,
      ST_EMIT  = 4'd8
   } state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic div_start;
      logic div_take;
      logic mul_p;
      logic mul_d;
      logic acc;
      logic steer;
      logic wheel;
      logic emit;
   } cmd_type;

   typedef struct packed {
      outcome_type outcome;
      logic        div_done;
      logic        out_free;
   } status_type;

   typedef struct packed {
      logic signed [DUTY_W-1:0] right;
      logic signed [DUTY_W-1:0] left;
   } wheel_pair_type;

endpackage

### design/lfps_req_if.sv
// request channel: one beat per control tick or command
// depends on lfps_pkg for field widths
interface lfps_req_if import lfps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic [7:0]               sensor_bits;
   logic signed [1:0]        turn_dir;

   modport source (output valid, output req_type, output sensor_bits, output turn_dir,
                   input ready);
   modport sink   (input valid, input req_type, input sensor_bits, input turn_dir,
                   output ready);
endinterface

### design/lfps_rsp_if.sv
// response channel: signed wheel duties, one beat per result
// depends on lfps_pkg for field widths
interface lfps_rsp_if import lfps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DUTY_W-1:0] right_speed;
   logic signed [DUTY_W-1:0] left_speed;

   modport source (output valid, output right_speed, output left_speed, input ready);
   modport sink   (input valid, input right_speed, input left_speed, output ready);
endinterface

### design/lfps_csr_if.sv
// register write channel: index and data, one beat per write
// depends on lfps_pkg for field widths
interface lfps_csr_if import lfps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/line_follow_pd_steering.sv
// channel | dir | payload                                  | beat
// req_ch  | in  | req_type, sensor_bits, turn_dir          | tick, start, stop or manual turn
// rsp_ch  | out | right_speed, left_speed                  | wheel duties, zero or one per req
// csr_ch  | in  | index, data                              | register write, always ready
//
// one request at a time; the next is accepted once the current one is through. a steering
// tick: decode, 7 divider steps plus handoff, two passes of the shared 14x17 multiplier,
// accumulate, steer limit, wheel clamp, output load. a direct result (stop, countdown,
// junction, lost line): decode, output load; no result: decode only.
// reset is synchronous and restores register defaults and clears steering state.
// a stalled rsp holds in the output register; req_ready returns once it is loaded.
//
// top level of the line follower pd steering block
// depends on lfps_pkg, the channel interfaces, lfps_ctrl and lfps_dp
`include "assert_macros.svh"

module line_follow_pd_steering import lfps_pkg::*; #(
   parameter int MAX_DUTY = 1000
) (
   input logic       clock,
   input logic       reset,
   lfps_req_if.sink  req_ch,
   lfps_rsp_if.source rsp_ch,
   lfps_csr_if.sink  csr_ch
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   lfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfps_dp #(
      .MAX_DUTY (MAX_DUTY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_ch.req_type),
      .sensor_bits (req_ch.sensor_bits),
      .turn_dir    (req_ch.turn_dir),
      .csr_write   (csr_ch.valid),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .right_speed (rsp_ch.right_speed),
      .left_speed  (rsp_ch.left_speed)
   );

   `ASSERT_NEXT(a_one_item_in_work, clock, reset, req_ch.valid && req_ready, !req_ready)
   `ASSERT_HOLDS(a_emit_never_overwrites, clock, reset, cmd.emit, status.out_free)
   `ASSERT_NEXT(a_emit_shows_valid, clock, reset, cmd.emit, rsp_ch.valid)
   `ASSERT_HOLDS(a_div_done_while_busy, clock, reset, status.div_done, !req_ready)

endmodule

### design/lfps_div.sv
// radix-4 restoring divider for the error mean: magnitude over black count
// depends on lfps_pkg; two quotient bits per cycle, done pulses after last step
module lfps_div import lfps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MAG_W-1:0]   dividend,
   input  logic [TOTAL_W-1:0] divisor,
   output logic               done,
   output logic [MAG_W-1:0]   quotient
);

   localparam int DQ_W  = 2 * DIV_STEPS;
   localparam int REM_W = 3;
   localparam int PR_W  = REM_W + 2;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DQ_W-1:0]      dq_ff, dq_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [TOTAL_W-1:0]   dvs_ff, dvs_in;

   logic [PR_W-1:0] part, d1, d2, d3;
   logic [1:0]      digit;
   logic [PR_W-1:0] part_left;

   always_comb begin
      d1   = PR_W'(dvs_ff);
      d2   = PR_W'({dvs_ff, 1'b0});
      d3   = d1 + d2;
      part = {rem_ff, dq_ff[DQ_W-1 -: 2]};
      priority if (part >= d3) begin
         digit     = 2'd3;
         part_left = part - d3;
      end else if (part >= d2) begin
         digit     = 2'd2;
         part_left = part - d2;
      end else if (part >= d1) begin
         digit     = 2'd1;
         part_left = part - d1;
      end else begin
         digit     = 2'd0;
         part_left = part;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = DQ_W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[DQ_W-3:0], digit};
         rem_in = part_left[REM_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff[MAG_W-1:0];

endmodule

### design/lfps_dp.sv
// datapath: registers, steering state, decode, shared multiplier, output register
// depends on lfps_pkg and lfps_div; driven by lfps_ctrl through cmd_type
module lfps_dp import lfps_pkg::*; #(
   parameter int MAX_DUTY = 1000
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [1:0]               req_type,
   input  logic [7:0]               sensor_bits,
   input  logic signed [1:0]        turn_dir,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DUTY_W-1:0] right_speed,
   output logic signed [DUTY_W-1:0] left_speed
);

   localparam logic signed [DUTY_W-1:0]  MaxDutyS = DUTY_W'(MAX_DUTY);
   localparam logic signed [WHEEL_W-1:0] MaxDutyW = WHEEL_W'(MAX_DUTY);

   function automatic logic signed [DUTY_W-1:0] sat_duty(input logic signed [DUTY_W-1:0] v);
      if (v > MaxDutyS) return MaxDutyS;
      if (v < -MaxDutyS) return -MaxDutyS;
      return v;
   endfunction

   function automatic logic signed [DUTY_W-1:0] clamp_wheel(
      input logic signed [WHEEL_W-1:0] v);
      if (v < 0) return '0;
      if (v > MaxDutyW) return MaxDutyS;
      return DUTY_W'(v);
   endfunction

   // negative direction spins right wheel forward
   function automatic wheel_pair_type spin_pair(input logic neg,
                                                input logic [SPEED_W-1:0] mag);
      logic signed [DUTY_W-1:0] m;
      m = $signed({1'b0, mag});
      spin_pair.right = neg ? m : -m;
      spin_pair.left  = neg ? -m : m;
   endfunction

   // configuration registers
   logic [SPEED_W-1:0] base_ff, turn_ff, search_ff;
   logic [CNT_W-1:0]   pre_len_ff, hold_len_ff;
   logic [GAIN_W-1:0]  kp_ff, kd_ff;
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= BASE_SPEED_RST;
         turn_ff     <= TURN_SPEED_RST;
         search_ff   <= SEARCH_SPEED_RST;
         pre_len_ff  <= PRE_TURN_RST;
         hold_len_ff <= TURN_HOLD_RST;
         kp_ff       <= KP_RST;
         kd_ff       <= KD_RST;
         limit_ff    <= STEER_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_SPEED:   base_ff     <= csr_data[SPEED_W-1:0];
            CSR_TURN_SPEED:   turn_ff     <= csr_data[SPEED_W-1:0];
            CSR_SEARCH_SPEED: search_ff   <= csr_data[SPEED_W-1:0];
            CSR_PRE_TURN_LEN: pre_len_ff  <= csr_data[CNT_W-1:0];
            CSR_TURN_HOLD:    hold_len_ff <= csr_data[CNT_W-1:0];
            CSR_KP:           kp_ff       <= csr_data[GAIN_W-1:0];
            CSR_KD:           kd_ff       <= csr_data[GAIN_W-1:0];
            CSR_STEER_LIMIT:  limit_ff    <= csr_data[LIMIT_W-1:0];
         endcase
      end
   end

   // latched request beat
   req_kind_type             kind_ff;
   logic [7:0]               sensor_ff;
   logic signed [1:0]        tdir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= REQ_TICK;
      end else if (cmd.load) begin
         kind_ff <= req_kind_type'(req_type);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sensor_ff <= sensor_bits;
         tdir_ff   <= turn_dir;
      end
   end

   // sensor reduction
   logic [7:0]              black;
   logic [TOTAL_W-1:0]      total;
   logic [SIDE_W-1:0]       right_cnt, left_cnt;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-1:0]        sum_abs;

   always_comb begin
      black     = ~sensor_ff;
      right_cnt = '0;
      left_cnt  = '0;
      sum       = '0;
      for (int i = 0; i < 4; i++) begin
         right_cnt = right_cnt + SIDE_W'(black[i]);
         left_cnt  = left_cnt + SIDE_W'(black[i+4]);
      end
      for (int i = 0; i < 8; i++) begin
         if (black[i]) begin
            sum = sum + SUM_W'(SENSOR_WEIGHT[i]);
         end
      end
      total   = TOTAL_W'(right_cnt) + TOTAL_W'(left_cnt);
      sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   end

   // steering state
   logic signed [ERR_W-1:0] last_err_ff, last_err_in;
   logic [CNT_W-1:0]        pre_cnt_ff, pre_cnt_in;
   logic [CNT_W-1:0]        hold_cnt_ff, hold_cnt_in;
   logic signed [1:0]       dir_ff, dir_in;
   logic                    need_white_ff, need_white_in;
   logic                    running_ff, running_in;

   // decode of the latched beat against the current state
   logic signed [ERR_W-1:0] dec_last_err;
   logic [CNT_W-1:0]        dec_pre, dec_hold;
   logic signed [1:0]       dec_dir;
   logic                    dec_nw, dec_run;
   wheel_pair_type          dec_res;
   outcome_type             outcome;
   wheel_pair_type          base_pair;

   always_comb begin
      base_pair.right = $signed({1'b0, base_ff});
      base_pair.left  = $signed({1'b0, base_ff});
      dec_last_err = last_err_ff;
      dec_pre      = pre_cnt_ff;
      dec_hold     = hold_cnt_ff;
      dec_dir      = dir_ff;
      dec_nw       = need_white_ff;
      dec_run      = running_ff;
      dec_res      = '0;
      outcome      = OUT_NONE;
      unique case (kind_ff)
         REQ_START, REQ_STOP: begin
            dec_last_err = '0;
            dec_pre      = '0;
            dec_hold     = '0;
            dec_nw       = 1'b0;
            dec_run      = (kind_ff == REQ_START);
            if (kind_ff == REQ_STOP) begin
               outcome = OUT_DIRECT;
            end
         end
         REQ_TURN: begin
            dec_dir  = tdir_ff;
            dec_hold = hold_len_ff;
            dec_nw   = 1'b0;
         end
         REQ_TICK: begin
            if (running_ff) begin
               outcome = OUT_DIRECT;
               if (hold_cnt_ff != '0) begin
                  dec_hold = hold_cnt_ff - 1'b1;
                  if (hold_cnt_ff == CNT_W'(1)) begin
                     dec_nw = 1'b1;
                  end
                  dec_res = spin_pair(dir_ff[1], turn_ff);
               end else if (pre_cnt_ff != '0) begin
                  dec_pre = pre_cnt_ff - 1'b1;
                  if (pre_cnt_ff == CNT_W'(1)) begin
                     dec_hold = hold_len_ff;
                     dec_res  = spin_pair(dir_ff[1], turn_ff);
                  end else begin
                     dec_res = base_pair;
                  end
               end else begin
                  if (total < JUNCTION_MIN) begin
                     dec_nw = 1'b0;
                  end
                  if (total >= JUNCTION_MIN && !need_white_ff) begin
                     // junction: go straight, then spin toward the heavier side
                     dec_last_err = '0;
                     dec_hold     = '0;
                     dec_nw       = 1'b0;
                     dec_dir      = (right_cnt > left_cnt) ? 2'sd1 : -2'sd1;
                     dec_pre      = pre_len_ff;
                     dec_res      = base_pair;
                  end else if (total == '0) begin
                     // line lost: search in the last turn sense, or straight if there is none
                     dec_last_err = '0;
                     dec_pre      = '0;
                     dec_hold     = '0;
                     dec_nw       = 1'b0;
                     if (dir_ff == '0) begin
                        dec_res.right = $signed({1'b0, search_ff});
                        dec_res.left  = $signed({1'b0, search_ff});
                     end else begin
                        dec_res = spin_pair(dir_ff[1], search_ff);
                     end
                  end else begin
                     outcome = OUT_PD;
                  end
               end
            end
         end
      endcase
   end

   // error mean through the divider
   logic             div_done;
   logic [MAG_W-1:0] quot;

   lfps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_abs[MAG_W-1:0]),
      .divisor  (total),
      .done     (div_done),
      .quotient (quot)
   );

   logic signed [ERR_W-1:0] err_val, err_ff;
   logic signed [SUM_W-1:0] deriv_val, deriv_ff;

   always_comb begin
      err_val   = sum[SUM_W-1] ? ERR_W'(-$signed(quot)) : $signed(quot);
      deriv_val = SUM_W'(err_val) - SUM_W'(last_err_ff);
   end

   always_comb begin
      last_err_in   = last_err_ff;
      pre_cnt_in    = pre_cnt_ff;
      hold_cnt_in   = hold_cnt_ff;
      dir_in        = dir_ff;
      need_white_in = need_white_ff;
      running_in    = running_ff;
      if (cmd.eval) begin
         last_err_in   = dec_last_err;
         pre_cnt_in    = dec_pre;
         hold_cnt_in   = dec_hold;
         dir_in        = dec_dir;
         need_white_in = dec_nw;
         running_in    = dec_run;
      end else if (cmd.div_take) begin
         last_err_in = err_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff   <= '0;
         pre_cnt_ff    <= '0;
         hold_cnt_ff   <= '0;
         dir_ff        <= '0;
         need_white_ff <= 1'b0;
         running_ff    <= 1'b0;
      end else begin
         last_err_ff   <= last_err_in;
         pre_cnt_ff    <= pre_cnt_in;
         hold_cnt_ff   <= hold_cnt_in;
         dir_ff        <= dir_in;
         need_white_ff <= need_white_in;
         running_ff    <= running_in;
      end
   end

   // shared multiplier: error times kp, then derivative times kd
   logic signed [SUM_W-1:0]    mul_a;
   logic signed [GAIN_W:0]     mul_b;
   logic signed [PROD_W-1:0]   prod, prod_p_ff, prod_d_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]           acc_abs;
   logic [SUM_W-1:0]           steer_mag;
   logic [LIMIT_W-1:0]         steer_sat;
   logic signed [SUM_W-1:0]    steer_ff, steer_in;
   logic signed [WHEEL_W-1:0]  base_w, right_w, left_w;
   wheel_pair_type             res_ff, res_in;

   always_comb begin
      mul_a = cmd.mul_d ? deriv_ff : SUM_W'(err_ff);
      mul_b = $signed({1'b0, cmd.mul_d ? kd_ff : kp_ff});
      prod  = mul_a * mul_b;
   end

   // magnitude shift truncates toward zero
   always_comb begin
      acc_abs   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      steer_mag = acc_abs[GAIN_W +: SUM_W];
      steer_sat = (steer_mag > SUM_W'(limit_ff)) ? limit_ff : steer_mag[LIMIT_W-1:0];
      steer_in  = acc_ff[ACC_W-1] ? -$signed(SUM_W'(steer_sat))
                                  : $signed(SUM_W'(steer_sat));
   end

   always_comb begin
      base_w  = $signed(WHEEL_W'(base_ff));
      right_w = base_w + WHEEL_W'(steer_ff);
      left_w  = base_w - WHEEL_W'(steer_ff);
      res_in  = res_ff;
      if (cmd.eval) begin
         res_in = dec_res;
      end else if (cmd.wheel) begin
         res_in.right = clamp_wheel(right_w);
         res_in.left  = clamp_wheel(left_w);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.div_take) begin
         err_ff   <= err_val;
         deriv_ff <= deriv_val;
      end
      if (cmd.mul_p) begin
         prod_p_ff <= prod;
      end
      if (cmd.mul_d) begin
         prod_d_ff <= prod;
      end
      if (cmd.acc) begin
         acc_ff <= ACC_W'(prod_p_ff) + ACC_W'(prod_d_ff);
      end
      if (cmd.steer) begin
         steer_ff <= steer_in;
      end
   end

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DUTY_W-1:0] right_ff, left_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         right_ff <= sat_duty(res_ff.right);
         left_ff  <= sat_duty(res_ff.left);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign right_speed = right_ff;
   assign left_speed  = left_ff;

   assign status.outcome  = outcome;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

### design/lfps_ctrl.sv
// controller: sequences one request beat through decode, then for pd ticks divide and multiply, then output
// depends on lfps_pkg; talks to lfps_dp through cmd_type and status_type
module lfps_ctrl import lfps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            unique case (status.outcome)
               OUT_PD: begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
               OUT_DIRECT: state_in = ST_EMIT;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_d = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_STEER;
         end
         ST_STEER: begin
            cmd.steer = 1'b1;
            state_in  = ST_WHEEL;
         end
         ST_WHEEL: begin
            cmd.wheel = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the output register to drain
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### tb/sv/tb_line_follow_pd_steering.sv
// self-checking testbench for the line follower pd steering block
// depends on lfps_pkg, the req, rsp and csr channel interfaces and the block itself
`timescale 1ns / 100ps

module tb_line_follow_pd_steering;
   import lfps_pkg::*;

   localparam int DUTY_MAX     = 1000;
   localparam int SETTLE_SLACK = 32;
   localparam int TAIL_CYCLES  = 40;
   localparam int STALL_LIMIT  = 2000;
   localparam int PRINT_CAP    = 40;

   localparam int LINE_WEIGHT [8] = '{3500, 2500, 1500, 500, -500, -1500, -2500, -3500};

   typedef struct {
      logic [9:0]  base;
      logic [9:0]  turn;
      logic [9:0]  search;
      logic [7:0]  pre;
      logic [7:0]  hold;
      logic [15:0] kp;
      logic [15:0] kd;
      logic [12:0] limit;
   } steer_regs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfps_req_if req_ch ();
   lfps_rsp_if rsp_ch ();
   lfps_csr_if csr_ch ();

   line_follow_pd_steering #(.MAX_DUTY(DUTY_MAX)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // predictor copy of the block state
   steer_regs_type active_regs;
   int             pd_last_err;
   int             pre_left;
   int             hold_left;
   int             heading;
   bit             need_white_flag;
   bit             drive_on;
   wheel_pair_type duty_expect [$];

   int error_count = 0;
   int idle_cycles = 0;
   bit burst       = 1'b0;
   bit req_raised  = 1'b0;

   function automatic steer_regs_type reset_regs();
      steer_regs_type r;
      r.base   = 10'd700;
      r.turn   = 10'd900;
      r.search = 10'd450;
      r.pre    = 8'd30;
      r.hold   = 8'd15;
      r.kp     = 16'd7864;
      r.kd     = 16'd52429;
      r.limit  = 13'd500;
      return r;
   endfunction

   function automatic steer_regs_type random_regs();
      steer_regs_type r;
      r.base   = $urandom_range(0, 1023);
      r.turn   = $urandom_range(0, 1023);
      r.search = $urandom_range(0, 1023);
      // short countdowns keep most ticks on the pd path
      r.pre    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      r.hold   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      r.kp     = $urandom_range(0, 65535);
      r.kd     = $urandom_range(0, 65535);
      r.limit  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 1200);
      return r;
   endfunction

   function automatic int draw_wait();
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic int limit_duty(int v);
      if (v > DUTY_MAX) return DUTY_MAX;
      if (v < -DUTY_MAX) return -DUTY_MAX;
      return v;
   endfunction

   function automatic int wheel_clamp(int v);
      if (v > DUTY_MAX) return DUTY_MAX;
      if (v < 0) return 0;
      return v;
   endfunction

   function automatic wheel_pair_type duty_pair(int right, int left);
      wheel_pair_type p;
      p.right = DUTY_W'(limit_duty(right));
      p.left  = DUTY_W'(limit_duty(left));
      return p;
   endfunction

   function automatic wheel_pair_type spin_pair(int dir, int mag);
      if (dir < 0) return duty_pair(mag, -mag);
      return duty_pair(-mag, mag);
   endfunction

   function automatic void clear_steer_state();
      pd_last_err     = 0;
      pre_left        = 0;
      hold_left       = 0;
      need_white_flag = 1'b0;
   endfunction

   function automatic wheel_pair_type steer_tick(logic [7:0] bits);
      int     i, blacks, right_n, left_n, wsum, err, deriv, steer;
      int     base, kp, kd, lim;
      longint acc;
      base    = active_regs.base;
      kp      = active_regs.kp;
      kd      = active_regs.kd;
      lim     = active_regs.limit;
      blacks  = 0;
      right_n = 0;
      left_n  = 0;
      wsum    = 0;
      if (hold_left > 0) begin
         hold_left--;
         if (hold_left == 0) need_white_flag = 1'b1;
         return spin_pair(heading, active_regs.turn);
      end
      if (pre_left > 0) begin
         pre_left--;
         if (pre_left == 0) begin
            hold_left = active_regs.hold;
            return spin_pair(heading, active_regs.turn);
         end
         return duty_pair(base, base);
      end
      for (i = 0; i < 8; i++) begin
         if (!bits[i]) begin
            blacks++;
            wsum += LINE_WEIGHT[i];
            if (i < 4) right_n++;
            else left_n++;
         end
      end
      if (blacks < 4) need_white_flag = 1'b0;
      if (blacks >= 4 && !need_white_flag) begin
         clear_steer_state();
         heading  = (right_n > left_n) ? 1 : -1;
         pre_left = active_regs.pre;
         return duty_pair(base, base);
      end
      if (blacks == 0) begin
         clear_steer_state();
         if (heading == 0) return duty_pair(active_regs.search, active_regs.search);
         return spin_pair(heading, active_regs.search);
      end
      err         = wsum / blacks;
      deriv       = err - pd_last_err;
      pd_last_err = err;
      acc = longint'(err) * longint'(kp) + longint'(deriv) * longint'(kd);
      // shift the magnitude so the quotient truncates toward zero
      if (acc < 0) steer = -int'((-acc) >> 16);
      else steer = int'(acc >> 16);
      if (steer > lim) steer = lim;
      if (steer < -lim) steer = -lim;
      return duty_pair(wheel_clamp(base + steer), wheel_clamp(base - steer));
   endfunction

   function automatic void predict_req(req_kind_type kind, logic [7:0] bits,
                                       logic signed [1:0] dir);
      case (kind)
         REQ_START: begin
            clear_steer_state();
            drive_on = 1'b1;
         end
         REQ_STOP: begin
            clear_steer_state();
            drive_on = 1'b0;
            duty_expect.push_back(duty_pair(0, 0));
         end
         REQ_TURN: begin
            heading         = dir;
            hold_left       = active_regs.hold;
            need_white_flag = 1'b0;
         end
         default: begin
            if (drive_on) duty_expect.push_back(steer_tick(bits));
         end
      endcase
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_CAP) $display("mismatch: %s", what);
   endtask

   // valid stays high across back-to-back beats; only a real gap lowers it
   task automatic send_req(req_kind_type kind, logic [7:0] bits, logic signed [1:0] dir);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         if (req_raised) req_ch.valid <= 1'b0;
         req_raised = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.sensor_bits <= bits;
      req_ch.turn_dir    <= dir;
      req_raised = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predict_req(kind, bits, dir);
   endtask

   task automatic wait_drained();
      if (req_raised) begin
         req_ch.valid <= 1'b0;
         req_raised = 1'b0;
         @(posedge clock);
      end
      while (duty_expect.size() != 0) @(posedge clock);
   endtask

   // items without a result may still be in flight once the queue is empty
   task automatic settle_idle();
      wait_drained();
      repeat (SETTLE_SLACK) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_BASE_SPEED:   active_regs.base   = value[9:0];
         CSR_TURN_SPEED:   active_regs.turn   = value[9:0];
         CSR_SEARCH_SPEED: active_regs.search = value[9:0];
         CSR_PRE_TURN_LEN: active_regs.pre    = value[7:0];
         CSR_TURN_HOLD:    active_regs.hold   = value[7:0];
         CSR_KP:           active_regs.kp     = value;
         CSR_KD:           active_regs.kd     = value;
         default:          active_regs.limit  = value[12:0];
      endcase
   endtask

   // unused upper data bits carry noise to show they are dropped
   task automatic program_regs(steer_regs_type r);
      settle_idle();
      write_csr(CSR_BASE_SPEED,   {6'($urandom), r.base});
      write_csr(CSR_TURN_SPEED,   {6'($urandom), r.turn});
      write_csr(CSR_SEARCH_SPEED, {6'($urandom), r.search});
      write_csr(CSR_PRE_TURN_LEN, {8'($urandom), r.pre});
      write_csr(CSR_TURN_HOLD,    {8'($urandom), r.hold});
      write_csr(CSR_KP,           r.kp);
      write_csr(CSR_KD,           r.kd);
      write_csr(CSR_STEER_LIMIT,  {3'($urandom), r.limit});
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [7:0] sensor_word(int junction_pct);
      int         pick, width, pos;
      logic [7:0] w;
      pick = $urandom_range(0, 99);
      w    = $urandom;
      if (pick < junction_pct) begin
         case ($urandom_range(0, 2))
            0:       w[3:0] = 4'h0;
            1:       w[7:4] = 4'h0;
            default: w = w & 8'($urandom);
         endcase
      end else if (pick < junction_pct + 8) begin
         w = 8'hFF;
      end else if (pick < junction_pct + 80) begin
         width = $urandom_range(1, 3);
         pos   = $urandom_range(0, 8 - width);
         w     = ~(8'((1 << width) - 1) << pos);
         if ($urandom_range(0, 9) == 0) w[$urandom_range(0, 7)] = ~w[$urandom_range(0, 7)];
      end
      return w;
   endfunction

   task automatic random_item(int junction_pct);
      int                pick;
      logic [7:0]        bits;
      logic signed [1:0] dir;
      req_kind_type      kind;
      pick = $urandom_range(0, 99);
      bits = $urandom;
      dir  = $urandom;
      if (!drive_on && pick < 85) kind = REQ_START;
      else if (pick < 3) kind = REQ_STOP;
      else if (pick < 5) kind = REQ_START;
      else if (pick < 9) kind = REQ_TURN;
      else begin
         kind = REQ_TICK;
         bits = sensor_word(junction_pct);
      end
      send_req(kind, bits, dir);
   endtask

   task automatic random_phase(steer_regs_type r, int count, int junction_pct);
      program_regs(r);
      repeat (count) begin
         if ($urandom_range(0, 63) == 0) burst = !burst;
         if ($urandom_range(0, 59) == 0) wait_drained();
         random_item(junction_pct);
      end
   endtask

   task automatic test_stopped_commands();
      send_req(REQ_TICK, 8'hE7, 2'sd0);
      send_req(REQ_STOP, 8'hFF, 2'sd0);
      send_req(REQ_TURN, 8'h00, 2'sd1);
      send_req(REQ_TICK, 8'h00, 2'sd0);
      send_req(REQ_START, 8'h00, -2'sd1);
      send_req(REQ_TICK, 8'hE7, 2'sd0);
      send_req(REQ_TICK, 8'hFE, 2'sd0);
      send_req(REQ_TICK, 8'h7F, 2'sd0);
      send_req(REQ_TICK, 8'hFC, 2'sd0);
      send_req(REQ_TICK, 8'hFF, 2'sd0);
      send_req(REQ_STOP, 8'h00, -2'sd2);
   endtask

   task automatic test_junction_turns();
      steer_regs_type r;
      r      = reset_regs();
      r.pre  = 8'd2;
      r.hold = 8'd2;
      program_regs(r);
      send_req(REQ_START, 8'hFF, 2'sd0);
      send_req(REQ_TICK, 8'hFF, 2'sd0);
      send_req(REQ_TICK, 8'h00, 2'sd0);
      send_req(REQ_TICK, 8'h5A, 2'sd0);
      send_req(REQ_TICK, 8'hA5, 2'sd0);
      send_req(REQ_TICK, 8'hFF, 2'sd0);
      send_req(REQ_TICK, 8'h00, 2'sd0);
      // junction word again before white is seen: steers instead
      send_req(REQ_TICK, 8'h00, 2'sd0);
      send_req(REQ_TICK, 8'hF0, 2'sd0);
      send_req(REQ_TICK, 8'hE7, 2'sd0);
      send_req(REQ_TICK, 8'hF0, 2'sd0);
      send_req(REQ_TICK, 8'hFF, 2'sd0);
      send_req(REQ_TICK, 8'hE7, 2'sd0);
      send_req(REQ_TICK, 8'hE7, 2'sd0);
      send_req(REQ_TURN, 8'hFF, -2'sd2);
      send_req(REQ_TICK, 8'hE7, 2'sd0);
      send_req(REQ_TICK, 8'hE7, 2'sd0);
      send_req(REQ_TURN, 8'hFF, 2'sd0);
      send_req(REQ_TICK, 8'h0F, 2'sd0);
      send_req(REQ_TICK, 8'h0F, 2'sd0);
      send_req(REQ_TICK, 8'hFF, 2'sd0);
   endtask

   task automatic test_register_extremes();
      steer_regs_type r;
      r.base   = 10'd1023;
      r.turn   = 10'd1023;
      r.search = 10'd1023;
      r.pre    = 8'd255;
      r.hold   = 8'd255;
      r.kp     = 16'd65535;
      r.kd     = 16'd65535;
      r.limit  = 13'd8191;
      program_regs(r);
      send_req(REQ_START, 8'h00, 2'sd0);
      send_req(REQ_TICK, 8'hFE, 2'sd0);
      send_req(REQ_TICK, 8'h7F, 2'sd0);
      send_req(REQ_TICK, 8'hFE, 2'sd0);
      send_req(REQ_TICK, 8'hFF, 2'sd0);
      send_req(REQ_TICK, 8'h00, 2'sd0);
      // full pre-turn and hold countdowns; sensor words are ignored meanwhile
      burst = 1'b1;
      repeat (512) send_req(REQ_TICK, 8'($urandom), 2'($urandom));
      burst = 1'b0;
      r.base   = 10'd0;
      r.turn   = 10'd0;
      r.search = 10'd0;
      r.pre    = 8'd0;
      r.hold   = 8'd0;
      r.kp     = 16'd0;
      r.kd     = 16'd0;
      r.limit  = 13'd0;
      random_phase(r, 40, 30);
   endtask

   task automatic test_random_drive();
      repeat (7) begin
         burst = ($urandom_range(0, 3) == 0);
         random_phase(random_regs(), 38, 8);
      end
      burst = 1'b0;
   endtask

   // result sink: random stall before each beat, then field checks
   initial begin : duty_monitor
      wheel_pair_type want;
      int             stall;
      rsp_ch.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (duty_expect.size() == 0) begin
            report_mismatch($sformatf("beat with nothing expected r=%0d l=%0d",
                                      rsp_ch.right_speed, rsp_ch.left_speed));
         end else begin
            want = duty_expect.pop_front();
            if (rsp_ch.right_speed !== want.right)
               report_mismatch($sformatf("right_speed got %0d want %0d",
                                         rsp_ch.right_speed, want.right));
            if (rsp_ch.left_speed !== want.left)
               report_mismatch($sformatf("left_speed got %0d want %0d",
                                         rsp_ch.left_speed, want.left));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= REQ_TICK;
      req_ch.sensor_bits <= 8'hFF;
      req_ch.turn_dir    <= 2'sd0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_BASE_SPEED;
      csr_ch.data        <= '0;
      active_regs = reset_regs();
      clear_steer_state();
      heading  = 0;
      drive_on = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_stopped_commands();
      test_junction_turns();
      test_register_extremes();
      test_random_drive();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
